[design/cfsm_pkg.sv]
package cfsm_pkg;

    localparam int WIDTH_W  = 4;
    localparam int SLANT_W  = 2;
    localparam int WEIGHT_W = 10;
    localparam int INDEX_W  = 6;
    localparam int SCORE_W  = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_WIDTH  = 2'd0,
        CFG_TARGET_SLANT  = 2'd1,
        CFG_TARGET_WEIGHT = 2'd2
    } cfg_index_t;

    localparam logic [WIDTH_W-1:0]  NORMAL_WIDTH  = 4'd5;
    localparam logic signed [5:0]   WIDTH_BASE    = 6'sd10;
    localparam logic signed [11:0]  WEIGHT_TOP    = 12'sd1000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_LIGHT  = 10'd400;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MEDIUM = 10'd500;
    localparam logic [SLANT_W-1:0]  SLANT_OBLIQUE = 2'd2;

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 4'd5;
    localparam logic [SLANT_W-1:0]  RESET_SLANT  = 2'd0;
    localparam logic [WEIGHT_W-1:0] RESET_WEIGHT = 10'd400;

    // Rows are the target slant, columns the candidate slant.
    localparam logic [1:0] SLANT_TABLE [3][3] = '{
        '{2'd3, 2'd1, 2'd2},
        '{2'd1, 2'd3, 2'd2},
        '{2'd1, 2'd2, 2'd3}
    };

    typedef struct packed {
        logic [WIDTH_W-1:0]  cand_width;
        logic [SLANT_W-1:0]  cand_slant;
        logic [WEIGHT_W-1:0] cand_weight;
        logic                last_cand;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] best_index;
        logic [SCORE_W-1:0] best_score;
    } out_word_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [SLANT_W-1:0]  slant;
        logic [WEIGHT_W-1:0] weight;
    } target_t;

    typedef struct packed {
        logic step;
        logic last;
    } trk_ctrl_t;

    function automatic logic [1:0] clamp_slant(input logic [SLANT_W-1:0] s);
        return (s > SLANT_OBLIQUE) ? SLANT_OBLIQUE : s;
    endfunction

endpackage

[design/cfsm_score.sv]
module cfsm_score (
    input  cfsm_pkg::target_t                    target,
    input  cfsm_pkg::in_word_t                   item,
    output logic [cfsm_pkg::SCORE_W-1:0]         score
);
    import cfsm_pkg::*;

    logic signed [5:0]  pw_s;
    logic signed [5:0]  cw_s;
    logic signed [5:0]  width_t;
    logic [WIDTH_W-1:0] width_term;
    logic signed [11:0] tw_s;
    logic signed [11:0] kw_s;
    logic signed [11:0] weight_t;
    logic [WEIGHT_W-1:0] weight_term;
    logic [1:0]         slant_term;

    assign pw_s = $signed({2'b00, target.width});
    assign cw_s = $signed({2'b00, item.cand_width});
    assign tw_s = $signed({2'b00, target.weight});
    assign kw_s = $signed({2'b00, item.cand_weight});

    always_comb
    begin
        if (target.width <= NORMAL_WIDTH)
        begin
            if (item.cand_width <= target.width)
                width_t = WIDTH_BASE - pw_s + cw_s;
            else
                width_t = WIDTH_BASE - cw_s;
        end
        else
        begin
            if (item.cand_width > target.width)
                width_t = WIDTH_BASE + pw_s - cw_s;
            else
                width_t = cw_s;
        end
        // A negative term saturates at zero; the rest fits four bits.
        width_term = (width_t < 0) ? '0 : width_t[WIDTH_W-1:0];
    end

    always_comb
    begin
        if (target.weight == item.cand_weight)
            weight_t = WEIGHT_TOP;
        else if (target.weight < WEIGHT_LIGHT)
        begin
            if (item.cand_weight <= target.weight)
                weight_t = WEIGHT_TOP - tw_s + kw_s;
            else
                weight_t = WEIGHT_TOP - kw_s;
        end
        else if (target.weight <= WEIGHT_MEDIUM)
        begin
            if (item.cand_weight >= target.weight && item.cand_weight <= WEIGHT_MEDIUM)
                weight_t = WEIGHT_TOP + tw_s - kw_s;
            else if (item.cand_weight <= target.weight)
                weight_t = $signed({2'b00, WEIGHT_MEDIUM}) + kw_s;
            else
                weight_t = WEIGHT_TOP - kw_s;
        end
        else
        begin
            if (item.cand_weight > target.weight)
                weight_t = WEIGHT_TOP + tw_s - kw_s;
            else
                weight_t = kw_s;
        end
        weight_term = (weight_t < 0) ? '0 : weight_t[WEIGHT_W-1:0];
    end

    assign slant_term = SLANT_TABLE[clamp_slant(target.slant)][clamp_slant(item.cand_slant)];

    // The weight term may carry into the slant bits, as plain addition does.
    assign score = {width_term, 16'd0} + {10'd0, slant_term, 8'd0}
                 + {{(SCORE_W-WEIGHT_W){1'b0}}, weight_term};

endmodule

[design/cfsm_tracker.sv]
module cfsm_tracker #(
    parameter int MAX_STYLES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfsm_pkg::trk_ctrl_t          ctrl,
    input  logic [cfsm_pkg::SCORE_W-1:0] score,
    input  logic                         out_ready,
    output logic                         slot_free,
    output logic                         out_valid,
    output cfsm_pkg::out_word_t          out_data
);
    import cfsm_pkg::*;

    localparam int CNT_W = $clog2(MAX_STYLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STYLES);

    logic [SCORE_W-1:0] top_score_reg, top_score_next;
    logic [INDEX_W-1:0] top_index_reg, top_index_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_data_reg, out_data_next;
    logic               scored;

    assign slot_free = !out_valid_reg || out_ready;
    assign scored    = ctrl.step && (cnt_reg < CNT_MAX);

    always_comb
    begin
        top_score_next = top_score_reg;
        top_index_next = top_index_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (scored)
        begin
            // Only a strictly greater score wins, so the earliest maximum stays.
            if (score > top_score_reg)
            begin
                top_score_next = score;
                top_index_next = INDEX_W'(cnt_reg);
            end
            cnt_next = cnt_reg + 1'b1;
        end
        if (ctrl.step && ctrl.last)
        begin
            out_valid_next           = 1'b1;
            out_data_next.best_index = top_index_next;
            out_data_next.best_score = top_score_next;
            top_score_next           = '0;
            top_index_next           = '0;
            cnt_next                 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_score_reg <= '0;
            top_index_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_score_reg <= top_score_next;
            top_index_reg <= top_index_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("candidate counter past its limit");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step && ctrl.last |=> cnt_reg == '0 && top_score_reg == '0 && out_valid_reg)
        else $error("set not closed after its last word");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step && ctrl.last |-> slot_free)
        else $error("result overwritten while still pending");

    a_score_needs_cand: assert property (@(posedge clk) disable iff (!rst_n)
        top_score_reg != '0 |-> cnt_reg != '0)
        else $error("best score held with no candidate counted");

endmodule

[design/css_font_style_match_unit.sv]
// Font style matcher: candidate styles of a set arrive one word per cycle on the
// input channel, are registered, scored against the configured target and folded
// into a running best as they leave that register. A word flagged last_cand yields
// one result word (index and score of the earliest highest-scoring candidate) in
// the result register, and the next set may start right behind it. Throughput is
// one candidate per cycle; the only stall comes from the single result register,
// when a last word meets a result not yet taken downstream. Candidates past
// MAX_STYLES in one set are counted out and not scored. Target registers must be
// written via cfg_we/cfg_index/cfg_data while the block is idle (not enforced).
module css_font_style_match_unit #(
    parameter int MAX_STYLES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cfsm_pkg::in_word_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cfsm_pkg::out_word_t             out_data,
    input  logic                            cfg_we,
    input  logic [cfsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfsm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cfsm_pkg::*;

    target_t            target_reg;
    logic               s1_valid_reg, s1_valid_next;
    in_word_t           s1_data_reg;
    logic               slot_free;
    logic               advance;
    logic [SCORE_W-1:0] score;
    trk_ctrl_t          ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg.width  <= RESET_WIDTH;
            target_reg.slant  <= RESET_SLANT;
            target_reg.weight <= RESET_WEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_WIDTH:  target_reg.width  <= cfg_data[WIDTH_W-1:0];
                CFG_TARGET_SLANT:  target_reg.slant  <= cfg_data[SLANT_W-1:0];
                CFG_TARGET_WEIGHT: target_reg.weight <= cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // A held word moves on unless it closes a set and the result slot is full.
    assign advance       = s1_valid_reg && (!s1_data_reg.last_cand || slot_free);
    assign in_ready      = !s1_valid_reg || advance;
    assign s1_valid_next = in_valid || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
    end

    cfsm_score u_score (
        .target (target_reg),
        .item   (s1_data_reg),
        .score  (score)
    );

    assign ctrl = '{step: advance, last: s1_data_reg.last_cand};

    cfsm_tracker #(
        .MAX_STYLES (MAX_STYLES)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .score     (score),
        .out_ready (out_ready),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

[tb/css_font_style_match_unit_tb.sv]
`timescale 1ns / 100ps

module css_font_style_match_unit_tb;

    import cfsm_pkg::*;

    localparam int MAX_CANDS     = 64;
    localparam int STD_WIDTH     = 5;
    localparam int WIDTH_SPAN    = 10;
    localparam int WT_TOP        = 1000;
    localparam int WT_LIGHT      = 400;
    localparam int WT_MEDIUM     = 500;
    localparam int SLANT_MAX     = 2;
    localparam int SLANT_PTS [3][3] = '{'{3, 1, 2}, '{1, 3, 2}, '{1, 2, 3}};
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RAND_PER_SET  = 20;
    localparam int NUM_TARGETS   = 12;

    // Target settings per phase: width, slant, weight. The first one is the reset value.
    localparam int TGT_WIDTH  [NUM_TARGETS] = '{5, 1, 9, 0, 15, 5, 6, 4, 10, 3, 7, 2};
    localparam int TGT_SLANT  [NUM_TARGETS] = '{0, 1, 2, 3, 0, 1, 2, 0, 1, 2, 0, 3};
    localparam int TGT_WEIGHT [NUM_TARGETS] = '{400, 0, 1000, 1023, 700, 399, 500, 501,
                                               300, 450, 600, 100};

    class style_match_board;
        int unsigned tgt_width;
        int unsigned tgt_slant;
        int unsigned tgt_weight;
        int unsigned run_score;
        int unsigned run_index;
        int unsigned cand_pos;
        out_word_t   awaited[$];
        int unsigned errors;
        int unsigned words;
        int unsigned sets;
        int unsigned results;

        function new();
            tgt_width  = 5;
            tgt_slant  = 0;
            tgt_weight = 400;
            run_score  = 0;
            run_index  = 0;
            cand_pos   = 0;
            errors     = 0;
            words      = 0;
            sets       = 0;
            results    = 0;
        endfunction

        function void set_target(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_TARGET_WIDTH:  tgt_width  = v[WIDTH_W-1:0];
                CFG_TARGET_SLANT:  tgt_slant  = v[SLANT_W-1:0];
                CFG_TARGET_WEIGHT: tgt_weight = v[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function int width_pts(int pw, int cw);
            int t;
            if (pw <= STD_WIDTH)
            begin
                t = (cw <= pw) ? WIDTH_SPAN - pw + cw : WIDTH_SPAN - cw;
            end
            else
            begin
                t = (cw > pw) ? WIDTH_SPAN + pw - cw : cw;
            end
            return (t < 0) ? 0 : t;
        endfunction

        function int weight_pts(int pw, int cw);
            int t;
            if (pw == cw)
            begin
                t = WT_TOP;
            end
            else if (pw < WT_LIGHT)
            begin
                t = (cw <= pw) ? WT_TOP - pw + cw : WT_TOP - cw;
            end
            else if (pw <= WT_MEDIUM)
            begin
                if (cw >= pw && cw <= WT_MEDIUM)
                    t = WT_TOP + pw - cw;
                else if (cw <= pw)
                    t = WT_MEDIUM + cw;
                else
                    t = WT_TOP - cw;
            end
            else
            begin
                t = (cw > pw) ? WT_TOP + pw - cw : cw;
            end
            return (t < 0) ? 0 : t;
        endfunction

        function int unsigned match_score(in_word_t w);
            int unsigned ts;
            int unsigned cs;
            int unsigned sc;
            ts = (tgt_slant > SLANT_MAX) ? SLANT_MAX : tgt_slant;
            cs = (w.cand_slant > SLANT_MAX) ? SLANT_MAX : w.cand_slant;
            sc = (width_pts(tgt_width, w.cand_width) << 16)
               + (SLANT_PTS[ts][cs] << 8)
               + weight_pts(tgt_weight, w.cand_weight);
            return sc & 32'hFFFFF;
        endfunction

        function void note_candidate(in_word_t w);
            int unsigned sc;
            out_word_t   res;
            words++;
            if (cand_pos < MAX_CANDS)
            begin
                sc = match_score(w);
                // Only a strictly higher score moves the best, so the first maximum stays.
                if (sc > run_score)
                begin
                    run_score = sc;
                    run_index = cand_pos & 6'h3F;
                end
                cand_pos++;
            end
            if (w.last_cand)
            begin
                res.best_index = run_index[INDEX_W-1:0];
                res.best_score = run_score[SCORE_W-1:0];
                awaited.push_back(res);
                sets++;
                run_score = 0;
                run_index = 0;
                cand_pos  = 0;
            end
        endfunction

        function void check_best(out_word_t got);
            out_word_t want;
            results++;
            if (awaited.size() == 0)
            begin
                $error("unexpected result word: best_index %0d best_score %0d",
                       got.best_index, got.best_score);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.best_index !== want.best_index)
            begin
                $error("best_index: expected %0d, actual %0d", want.best_index, got.best_index);
                errors++;
            end
            if (got.best_score !== want.best_score)
            begin
                $error("best_score: expected %0d, actual %0d", want.best_score, got.best_score);
                errors++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    style_match_board board = new();
    bit          idle_on   = 1'b1;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned long_sets = 0;

    css_font_style_match_unit #(
        .MAX_STYLES(MAX_CANDS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Monitors sample the values that were present just before the edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_candidate(in_data);
        if (rst_n && out_valid && out_ready)
            board.check_best(out_data);
    end

    // Receiver: random stall bursts, only while idle_on is set.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("css_font_style_match_unit regression: fail");
            $finish;
        end
    end

    task automatic send_cand(input in_word_t w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_fields(input int cw, input int cs, input int cwt, input bit last);
        in_word_t w;
        w.cand_width  = WIDTH_W'(cw);
        w.cand_slant  = SLANT_W'(cs);
        w.cand_weight = WEIGHT_W'(cwt);
        w.last_cand   = last;
        send_cand(w);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Waits until every result is in; SETTLE_CYCLES more cover the pipeline tail.
    task automatic apply_target(input int tw, input int ts, input int twt);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TARGET_WIDTH;
        cfg_data  <= CFG_DATA_W'(tw);
        @(posedge clk);
        board.set_target(CFG_TARGET_WIDTH, CFG_DATA_W'(tw));
        cfg_index <= CFG_TARGET_SLANT;
        cfg_data  <= CFG_DATA_W'(ts);
        @(posedge clk);
        board.set_target(CFG_TARGET_SLANT, CFG_DATA_W'(ts));
        cfg_index <= CFG_TARGET_WEIGHT;
        cfg_data  <= CFG_DATA_W'(twt);
        @(posedge clk);
        board.set_target(CFG_TARGET_WEIGHT, CFG_DATA_W'(twt));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_width();
        if ($urandom_range(0, 6) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(1, 9);
    endfunction

    function automatic int pick_weight(int target);
        int v;
        case ($urandom_range(0, 9))
            0: v = target;
            1: v = $urandom_range(1001, 1023);
            2: v = target + $urandom_range(0, 40) - 20;
            3: v = $urandom_range(0, 1) ? 0 : 1000;
            default: v = $urandom_range(0, 1000);
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v;
    endfunction

    task automatic random_set(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_fields(pick_width(), $urandom_range(0, 3), pick_weight(board.tgt_weight),
                        i == n - 1);
    endtask

    // A set past the candidate limit; optionally the best sits at the last scored slot.
    task automatic long_set(input bit best_at_end);
        int n;
        int i;
        n = $urandom_range(MAX_CANDS + 1, MAX_CANDS + 8);
        long_sets++;
        for (i = 0; i < n; i++)
        begin
            if (!best_at_end)
                send_fields(pick_width(), $urandom_range(0, 3),
                            pick_weight(board.tgt_weight), i == n - 1);
            else if (i < MAX_CANDS - 1)
                send_fields(0, (board.tgt_slant + 1) % 3, $urandom_range(0, 1023), 1'b0);
            else
                send_fields(board.tgt_width, board.tgt_slant, board.tgt_weight, i == n - 1);
        end
    endtask

    initial
    begin
        int ph;
        int sent;
        int n;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets under the reset target.
        send_fields(5, 0, 400, 1'b1);
        send_fields(0, 3, 1023, 1'b0);
        send_fields(15, 3, 0, 1'b0);
        send_fields(9, 1, 1000, 1'b0);
        send_fields(1, 2, 401, 1'b1);
        send_fields(15, 3, 1023, 1'b1);
        send_fields(4, 1, 450, 1'b0);
        send_fields(4, 1, 450, 1'b0);
        send_fields(3, 2, 300, 1'b1);
        send_fields(10, 0, 500, 1'b0);
        send_fields(11, 1, 501, 1'b0);
        send_fields(6, 0, 399, 1'b0);
        send_fields(5, 0, 1001, 1'b0);
        send_fields(5, 0, 400, 1'b1);
        send_fields(8, 2, 200, 1'b0);
        send_fields(2, 1, 700, 1'b1);
        send_fields(5, 0, 400, 1'b0);
        send_fields(5, 0, 400, 1'b1);

        for (ph = 0; ph < NUM_TARGETS; ph++)
        begin
            if (ph > 0)
                apply_target(TGT_WIDTH[ph], TGT_SLANT[ph], TGT_WEIGHT[ph]);
            if (ph == NUM_TARGETS - 1)
                idle_on = 1'b0;
            sent = 0;
            while (sent < RAND_PER_SET)
            begin
                n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 5) : $urandom_range(6, 16);
                random_set(n);
                sent += n;
                // Sender holds off once until the block has caught up.
                if (ph == 3 && sent >= RAND_PER_SET / 2 && sent - n < RAND_PER_SET / 2)
                    wait_for_results();
            end
            if (ph == 2 || ph == 6)
                long_set(1'b0);
            if (ph == 4 || ph == 9)
                long_set(1'b1);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("covered %0d candidate words in %0d sets over %0d target settings,",
                 board.words, board.sets, NUM_TARGETS);
        $display("including %0d sets past the candidate limit; %0d result words checked",
                 long_sets, board.results);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("css_font_style_match_unit regression: pass");
        else
            $display("css_font_style_match_unit regression: fail");
        $finish;
    end

endmodule

[css_font_style_match_unit.f]
design/cfsm_pkg.sv
design/cfsm_score.sv
design/cfsm_tracker.sv
design/css_font_style_match_unit.sv
tb/css_font_style_match_unit_tb.sv
